// ===== hw/rtl/cau_pkg.sv =====
// Package for the complex arithmetic unit: op codes, status codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package cau_pkg;
  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned OpW          = 3;
  localparam int unsigned StW          = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_CONJ = 3'd5,
    OP_EQ   = 3'd6,
    OP_NOP  = 3'd7
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_RSV  = 2'd3
  } status_e;
endpackage

// ===== hw/rtl/cau_front.sv =====
// Front stage: sign-magnitude products, numerators, denominator, simple ops.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_front #(
  parameter int unsigned DataWidth = cau_pkg::DataWidthDef,
  parameter int unsigned FracBits  = cau_pkg::FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [cau_pkg::OpW-1:0] op_i,
  input  logic [DataWidth-1:0]   ar_i,
  input  logic [DataWidth-1:0]   ai_i,
  input  logic [DataWidth-1:0]   br_i,
  input  logic [DataWidth-1:0]   bi_i,
  output logic                   vld_o,
  output logic [cau_pkg::OpW-1:0] op_o,
  output logic                   nr_neg_o,
  output logic [2*DataWidth:0]   nr_mag_o,
  output logic                   ni_neg_o,
  output logic [2*DataWidth:0]   ni_mag_o,
  output logic [2*DataWidth:0]   den_o,
  output logic                   eq_o
);
  import cau_pkg::*;
  localparam int unsigned PW = 2*DataWidth + 2;

  logic signed [PW-1:0] pa_d, pb_d, pc_d, pd_d, nr_d, ni_d, den_d;
  logic signed [PW-1:0] ar, ai, br, bi;
  logic vld_q;
  logic [OpW-1:0] op_q;
  logic nr_neg_q, ni_neg_q, eq_q;
  logic [2*DataWidth:0] nr_q, ni_q, den_q;
  logic [PW-1:0] nr_abs, ni_abs;

  always_comb begin
    ar = PW'(signed'(ar_i));
    ai = PW'(signed'(ai_i));
    br = PW'(signed'(br_i));
    bi = PW'(signed'(bi_i));
    pa_d = ar * br;
    pb_d = ai * bi;
    pc_d = ar * bi;
    pd_d = ai * br;
    den_d = pa_d;
    nr_d = '0;
    ni_d = '0;
    case (op_e'(op_i))
      OP_ADD: begin nr_d = (ar + br) <<< FracBits; ni_d = (ai + bi) <<< FracBits; end
      OP_SUB: begin nr_d = (ar - br) <<< FracBits; ni_d = (ai - bi) <<< FracBits; end
      OP_MUL: begin nr_d = pa_d - pb_d; ni_d = pc_d + pd_d; end
      OP_DIV: begin nr_d = pa_d + pb_d; ni_d = pd_d - pc_d; end
      OP_NEG: begin nr_d = (-ar) <<< FracBits; ni_d = (-ai) <<< FracBits; end
      OP_CONJ: begin nr_d = ar <<< FracBits; ni_d = (-ai) <<< FracBits; end
      default: begin nr_d = '0; ni_d = '0; end
    endcase
    den_d = br * br + bi * bi;
    nr_abs = nr_d[PW-1] ? PW'(-nr_d) : PW'(nr_d);
    ni_abs = ni_d[PW-1] ? PW'(-ni_d) : PW'(ni_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q     <= op_i;
      nr_neg_q <= nr_d[PW-1];
      ni_neg_q <= ni_d[PW-1];
      nr_q     <= nr_abs[2*DataWidth:0];
      ni_q     <= ni_abs[2*DataWidth:0];
      den_q    <= den_d[2*DataWidth:0];
      eq_q     <= (ar_i == br_i) && (ai_i == bi_i);
    end
  end

  assign vld_o = vld_q;
  assign op_o = op_q;
  assign nr_neg_o = nr_neg_q;
  assign ni_neg_o = ni_neg_q;
  assign nr_mag_o = nr_q;
  assign ni_mag_o = ni_q;
  assign den_o = den_q;
  assign eq_o = eq_q;
endmodule

// ===== hw/rtl/cau_div_cell.sv =====
// One restoring-division cell: produces one quotient bit for each part.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_div_cell #(
  parameter int unsigned DataWidth = cau_pkg::DataWidthDef,
  parameter int unsigned QW        = 2*cau_pkg::DataWidthDef + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [cau_pkg::OpW-1:0] op_i,
  input  logic                   eq_i,
  input  logic                   nr_neg_i,
  input  logic                   ni_neg_i,
  input  logic [2*DataWidth:0]   den_i,
  input  logic [2*DataWidth+1:0] rr_i,
  input  logic [2*DataWidth+1:0] ri_i,
  input  logic [QW-1:0]          qr_i,
  input  logic [QW-1:0]          qi_i,
  input  logic                   br_i,
  input  logic                   bi_i,
  output logic                   vld_o,
  output logic [cau_pkg::OpW-1:0] op_o,
  output logic                   eq_o,
  output logic                   nr_neg_o,
  output logic                   ni_neg_o,
  output logic [2*DataWidth:0]   den_o,
  output logic [2*DataWidth+1:0] rr_o,
  output logic [2*DataWidth+1:0] ri_o,
  output logic [QW-1:0]          qr_o,
  output logic [QW-1:0]          qi_o
);
  import cau_pkg::*;
  localparam int unsigned RW = 2*DataWidth + 2;

  logic [RW-1:0] tr, ti, rr_d, ri_d;
  logic gr, gi, vld_q;
  logic [OpW-1:0] op_q;
  logic eq_q, nrn_q, nin_q;
  logic [2*DataWidth:0] den_q;
  logic [RW-1:0] rr_q, ri_q;
  logic [QW-1:0] qr_q, qi_q;

  always_comb begin
    tr = {rr_i[RW-2:0], br_i};
    ti = {ri_i[RW-2:0], bi_i};
    gr = tr >= RW'(den_i);
    gi = ti >= RW'(den_i);
    rr_d = gr ? tr - RW'(den_i) : tr;
    ri_d = gi ? ti - RW'(den_i) : ti;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q  <= op_i;
      eq_q  <= eq_i;
      nrn_q <= nr_neg_i;
      nin_q <= ni_neg_i;
      den_q <= den_i;
      rr_q  <= rr_d;
      ri_q  <= ri_d;
      qr_q  <= {qr_i[QW-2:0], gr};
      qi_q  <= {qi_i[QW-2:0], gi};
    end
  end

  assign vld_o = vld_q;
  assign op_o = op_q;
  assign eq_o = eq_q;
  assign nr_neg_o = nrn_q;
  assign ni_neg_o = nin_q;
  assign den_o = den_q;
  assign rr_o = rr_q;
  assign ri_o = ri_q;
  assign qr_o = qr_q;
  assign qi_o = qi_q;
endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit, Q-format add/sub/mul/div/neg/conj/equal.
// Pipeline: m_axis_tvalid rises after the input beat passes the front stage, one
// divider cell per quotient bit, and the output register.
// Throughput: one beat per cycle while the output register is not stalled.
// The whole pipeline advances together; it stalls only when the output
// register holds a beat that is not taken. Reset clears valid bits only.
// Depends on cau_pkg, cau_front, cau_div_cell.
`timescale 1ns / 1ps
module complex_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = cau_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // operation, a_real, a_imag, b_real, b_imag (zero padded)
  input  logic [((cau_pkg::OpW+4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_real, res_imag, is_equal, status (zero padded)
  output logic [((2*DATA_WIDTH+3+7)/8)*8-1:0] m_axis_tdata
);
  import cau_pkg::*;
  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned NB = 2*DW + 1;        // numerator bits
  localparam int unsigned NC = NB + FRAC_BITS;  // quotient bits = cells
  localparam int unsigned RW = 2*DW + 2;
  localparam int unsigned OW = ((2*DW+3+7)/8)*8;

  logic en;
  logic f_vld, f_nrn, f_nin, f_eq;
  logic [OpW-1:0] f_op;
  logic [NB-1:0] f_nr, f_ni, f_den;
  // numerators scaled by 2^FRAC_BITS for the divider
  logic [NC-1:0] f_nx, f_nix;

  // chain signals, index k = input of cell k
  logic           c_vld [NC+1];
  logic [OpW-1:0] c_op  [NC+1];
  logic           c_eq  [NC+1];
  logic           c_nrn [NC+1];
  logic           c_nin [NC+1];
  logic [NB-1:0]  c_den [NC+1];
  logic [RW-1:0]  c_rr  [NC+1];
  logic [RW-1:0]  c_ri  [NC+1];
  logic [NC-1:0]  c_qr  [NC+1];
  logic [NC-1:0]  c_qi  [NC+1];
  // numerator bits ride along a delay line per cell
  logic [NC-1:0]  nr_sh_q [NC-1];
  logic [NC-1:0]  ni_sh_q [NC-1];

  logic out_vld_q;
  logic [OW-1:0] out_q, out_d;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  cau_front #(.DataWidth(DW), .FracBits(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(s_axis_tvalid),
    .op_i(s_axis_tdata[OpW-1:0]),
    .ar_i(s_axis_tdata[OpW +: DW]),
    .ai_i(s_axis_tdata[OpW+DW +: DW]),
    .br_i(s_axis_tdata[OpW+2*DW +: DW]),
    .bi_i(s_axis_tdata[OpW+3*DW +: DW]),
    .vld_o(f_vld), .op_o(f_op), .nr_neg_o(f_nrn), .nr_mag_o(f_nr),
    .ni_neg_o(f_nin), .ni_mag_o(f_ni), .den_o(f_den), .eq_o(f_eq)
  );

  assign f_nx  = NC'(f_nr) << FRAC_BITS;
  assign f_nix = NC'(f_ni) << FRAC_BITS;

  assign c_vld[0] = f_vld;
  assign c_op[0]  = f_op;
  assign c_eq[0]  = f_eq;
  assign c_nrn[0] = f_nrn;
  assign c_nin[0] = f_nin;
  assign c_den[0] = f_den;
  assign c_rr[0]  = '0;
  assign c_ri[0]  = '0;
  assign c_qr[0]  = '0;
  assign c_qi[0]  = '0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nr_sh_q[0] <= f_nx << 1;
      ni_sh_q[0] <= f_nix << 1;
      for (int k = 1; k < NC-1; k++) begin
        nr_sh_q[k] <= nr_sh_q[k-1] << 1;
        ni_sh_q[k] <= ni_sh_q[k-1] << 1;
      end
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    logic bnr, bni;
    if (k == 0) begin : g_first
      assign bnr = f_nx[NC-1];
      assign bni = f_nix[NC-1];
    end else begin : g_rest
      assign bnr = nr_sh_q[k-1][NC-1];
      assign bni = ni_sh_q[k-1][NC-1];
    end
    cau_div_cell #(.DataWidth(DW), .QW(NC)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(c_vld[k]), .op_i(c_op[k]), .eq_i(c_eq[k]),
      .nr_neg_i(c_nrn[k]), .ni_neg_i(c_nin[k]), .den_i(c_den[k]),
      .rr_i(c_rr[k]), .ri_i(c_ri[k]), .qr_i(c_qr[k]), .qi_i(c_qi[k]),
      .br_i(bnr), .bi_i(bni),
      .vld_o(c_vld[k+1]), .op_o(c_op[k+1]), .eq_o(c_eq[k+1]),
      .nr_neg_o(c_nrn[k+1]), .ni_neg_o(c_nin[k+1]), .den_o(c_den[k+1]),
      .rr_o(c_rr[k+1]), .ri_o(c_ri[k+1]), .qr_o(c_qr[k+1]), .qi_o(c_qi[k+1])
    );
  end

  // Final selection: quotient for divide, floor shift for the rest.
  // Non-divide ops carry value << FRAC_BITS in the numerator so one path
  // with floor (neg: ceil of magnitude) serves them all.
  logic [NB-1:0] num_r, num_i;
  logic [NC-1:0] mag_r, mag_i;
  logic neg_r, neg_i, sat_r, sat_i, divz, is_div;
  logic [DW-1:0] fr, fi;
  logic [NC-1:0] lim;
  logic [OpW-1:0] lop;
  logic [NB-1:0] rnd;

  assign lop = c_op[NC];

  // unscaled numerator magnitudes, delayed to line up with the last cell
  logic [NB-1:0] raw_r_q [NC];
  logic [NB-1:0] raw_i_q [NC];
  always_ff @(posedge clk_i) begin
    if (en) begin
      raw_r_q[0] <= f_nr;
      raw_i_q[0] <= f_ni;
      for (int k = 1; k < NC; k++) begin
        raw_r_q[k] <= raw_r_q[k-1];
        raw_i_q[k] <= raw_i_q[k-1];
      end
    end
  end
  assign num_r = raw_r_q[NC-1];
  assign num_i = raw_i_q[NC-1];

  always_comb begin
    is_div = op_e'(lop) == OP_DIV;
    divz = is_div && (c_den[NC] == '0);
    neg_r = c_nrn[NC];
    neg_i = c_nin[NC];
    rnd = NB'((64'd1 << FRAC_BITS) - 64'd1);
    if (is_div) begin
      mag_r = c_qr[NC];
      mag_i = c_qi[NC];
    end else begin
      mag_r = neg_r ? NC'((num_r + rnd) >> FRAC_BITS) : NC'(num_r >> FRAC_BITS);
      mag_i = neg_i ? NC'((num_i + rnd) >> FRAC_BITS) : NC'(num_i >> FRAC_BITS);
    end
    lim = NC'(64'd1 << (DW-1));
    if (mag_r == '0) neg_r = 1'b0;
    if (mag_i == '0) neg_i = 1'b0;
    sat_r = neg_r ? (mag_r > lim) : (mag_r > lim - 1'b1);
    sat_i = neg_i ? (mag_i > lim) : (mag_i > lim - 1'b1);
    fr = sat_r ? (neg_r ? DW'(-lim) : DW'(lim - 1'b1))
               : (neg_r ? DW'(-mag_r) : DW'(mag_r));
    fi = sat_i ? (neg_i ? DW'(-lim) : DW'(lim - 1'b1))
               : (neg_i ? DW'(-mag_i) : DW'(mag_i));
  end

  always_comb begin
    out_d = '0;
    case (op_e'(lop))
      OP_EQ: out_d[2*DW] = c_eq[NC];
      OP_NOP: out_d = '0;
      default: begin
        if (divz) begin
          out_d[2*DW+1 +: StW] = ST_DIVZ;
        end else begin
          out_d[DW-1:0] = fr;
          out_d[DW +: DW] = fi;
          out_d[2*DW+1 +: StW] = (sat_r || sat_i) ? ST_SAT : ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= c_vld[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = out_q;
endmodule
